[rtl/core/a64tw_pkg.sv]
// shared types, codes and helpers of the 4 KB granule table walker
package a64tw_pkg;

	// widths of the fixed fields
	localparam int ADDR_W    = 48;
	localparam int DESC_W    = 64;
	localparam int VA_SZ_W   = 6;
	localparam int LEVEL_W   = 2;
	localparam int CFG_IDX_W = 1;

	// default physical address width kept from bases and descriptors
	localparam int OUT_ADDR_BITS_DEF = 48;

	// legal T0SZ range: VA width from 13 to 48 bits
	localparam logic [VA_SZ_W-1:0] VA_SZ_MIN = VA_SZ_W'(64 - 48);
	localparam logic [VA_SZ_W-1:0] VA_SZ_MAX = VA_SZ_W'(64 - 13);

	// T0SZ upper bounds for start levels 0, 1 and 2
	localparam logic [VA_SZ_W-1:0] VA_SZ_LVL0_MAX = VA_SZ_W'(64 - 40);
	localparam logic [VA_SZ_W-1:0] VA_SZ_LVL1_MAX = VA_SZ_W'(64 - 31);
	localparam logic [VA_SZ_W-1:0] VA_SZ_LVL2_MAX = VA_SZ_W'(64 - 22);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_VA_SZ      = 1'b1;

	// reset values of the configuration registers
	localparam logic [ADDR_W-1:0]  TABLE_BASE_RST = '0;
	localparam logic [VA_SZ_W-1:0] VA_SZ_RST      = VA_SZ_W'(16);

	// table levels
	localparam logic [LEVEL_W-1:0] LEVEL_0 = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_1 = 2'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_2 = 2'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_3 = 2'd3;

	// input command codes
	typedef enum logic {
		CMD_TRANSLATE = 1'b0,
		CMD_RESPONSE  = 1'b1
	} cmd_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_FAULT = 2'd2,
		KIND_BUSY  = 2'd3
	} kind_t;

	// walk context carried from one item to the next
	typedef struct packed {
		logic               walking;
		logic [LEVEL_W-1:0] level;
		logic [ADDR_W-1:0]  va;
	} walk_state_t;

	// one result item
	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  addr;
		logic [LEVEL_W-1:0] level;
	} result_t;

	// 9-bit table index of a virtual address at a level
	function automatic logic [8:0] va_index(input logic [ADDR_W-1:0] va,
			input logic [LEVEL_W-1:0] lvl);
		logic [8:0] idx;
		case (lvl)
			LEVEL_0: idx = va[47:39];
			LEVEL_1: idx = va[38:30];
			LEVEL_2: idx = va[29:21];
			LEVEL_3: idx = va[20:12];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

	// offset mask of a block or page mapped at a level
	function automatic logic [ADDR_W-1:0] map_offset_mask(input logic [LEVEL_W-1:0] lvl);
		logic [ADDR_W-1:0] m;
		case (lvl)
			LEVEL_0: m = {{(ADDR_W-39){1'b0}}, {39{1'b1}}};
			LEVEL_1: m = {{(ADDR_W-30){1'b0}}, {30{1'b1}}};
			LEVEL_2: m = {{(ADDR_W-21){1'b0}}, {21{1'b1}}};
			LEVEL_3: m = {{(ADDR_W-12){1'b0}}, {12{1'b1}}};
			default: m = {{(ADDR_W-12){1'b0}}, {12{1'b1}}};
		endcase
		return m;
	endfunction

	// start level from T0SZ, legal range only
	function automatic logic [LEVEL_W-1:0] walk_entry_level(input logic [VA_SZ_W-1:0] va_sz);
		logic [LEVEL_W-1:0] lvl;
		if (va_sz <= VA_SZ_LVL0_MAX) begin
			lvl = LEVEL_0;
		end else if (va_sz <= VA_SZ_LVL1_MAX) begin
			lvl = LEVEL_1;
		end else if (va_sz <= VA_SZ_LVL2_MAX) begin
			lvl = LEVEL_2;
		end else begin
			lvl = LEVEL_3;
		end
		return lvl;
	endfunction

endpackage

[rtl/core/aarch64_4k_table_walker.sv]
// top level of the 4 KB granule stage-1 table walker
//
//  channel  | signals                                      | role
//  ---------+----------------------------------------------+------------------------------
//  in       | in_valid in_ready cmd virt_addr descriptor   | translate request or
//           | bus_error                                    | descriptor response
//  out      | out_valid out_ready kind out_addr walk_level | read request, done, fault, busy
//  cfg      | cfg_we cfg_index cfg_data                    | table base and T0SZ writes
//
// one item per cycle while the result is taken: an input register, then one
// decode pass into the result register.
// the walk context updates as an item leaves the input register, so the next
// item sees it without a gap. reset clears context, loads config defaults, no sweep.
// a stalled result holds the input register; in_ready drops only when both
// registers are full and the result is not taken.
module aarch64_4k_table_walker #(
	parameter int OUT_ADDR_BITS = a64tw_pkg::OUT_ADDR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            cmd,
	input  logic [a64tw_pkg::ADDR_W-1:0]    virt_addr,
	input  logic [a64tw_pkg::DESC_W-1:0]    descriptor,
	input  logic                            bus_error,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      kind,
	output logic [a64tw_pkg::ADDR_W-1:0]    out_addr,
	output logic [a64tw_pkg::LEVEL_W-1:0]   walk_level,
	input  logic                            cfg_we,
	input  logic [a64tw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [a64tw_pkg::ADDR_W-1:0]    cfg_data
);

	logic                             valid_s1;
	logic                             cmd_s1;
	logic [a64tw_pkg::ADDR_W-1:0]     va_s1;
	logic [a64tw_pkg::ADDR_W-1:0]     desc_s1;
	logic                             berr_s1;
	logic                             valid_s2;
	a64tw_pkg::result_t               res_s2;
	a64tw_pkg::result_t               res_next;
	a64tw_pkg::walk_state_t           walk_q;
	a64tw_pkg::walk_state_t           walk_next;
	logic [a64tw_pkg::ADDR_W-1:0]     base_q;
	logic [a64tw_pkg::VA_SZ_W-1:0]    va_sz_q;
	logic                             adv_s1;
	logic                             in_xfer;

	// handshake
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_xfer  = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= a64tw_pkg::TABLE_BASE_RST;
			va_sz_q <= a64tw_pkg::VA_SZ_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				a64tw_pkg::CFG_TABLE_BASE: base_q  <= cfg_data;
				a64tw_pkg::CFG_VA_SZ:      va_sz_q <= cfg_data[a64tw_pkg::VA_SZ_W-1:0];
				default:                   base_q  <= base_q;
			endcase
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1  <= cmd;
			va_s1   <= virt_addr;
			desc_s1 <= descriptor[a64tw_pkg::ADDR_W-1:0];
			berr_s1 <= bus_error;
		end
	end

	// decode pass
	a64tw_step #(
		.OUT_ADDR_BITS(OUT_ADDR_BITS)
	) u_step (
		.cfg_base  (base_q),
		.cfg_va_sz (va_sz_q),
		.cmd       (cmd_s1),
		.virt_addr (va_s1),
		.descriptor(desc_s1),
		.bus_error (berr_s1),
		.cur       (walk_q),
		.nxt       (walk_next),
		.res       (res_next)
	);

	// walk context, updated as an item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (adv_s1) begin
			walk_q <= walk_next;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid  = valid_s2;
	assign kind       = res_s2.kind;
	assign out_addr   = res_s2.addr;
	assign walk_level = res_s2.level;

endmodule

[rtl/core/a64tw_step.sv]
// single-step walk decode: one input item against the walk context
module a64tw_step #(
	parameter int OUT_ADDR_BITS = a64tw_pkg::OUT_ADDR_BITS_DEF
) (
	input  logic [a64tw_pkg::ADDR_W-1:0]  cfg_base,
	input  logic [a64tw_pkg::VA_SZ_W-1:0] cfg_va_sz,
	input  logic                          cmd,
	input  logic [a64tw_pkg::ADDR_W-1:0]  virt_addr,
	input  logic [a64tw_pkg::ADDR_W-1:0]  descriptor,
	input  logic                          bus_error,
	input  a64tw_pkg::walk_state_t        cur,
	output a64tw_pkg::walk_state_t        nxt,
	output a64tw_pkg::result_t            res
);

	// kept address bits 47..12, limited by the output address width
	localparam logic [63:0] ADDR_MASK_WIDE =
		((64'd1 << OUT_ADDR_BITS) - 64'd1) & ~64'hfff;
	localparam logic [a64tw_pkg::ADDR_W-1:0] ADDR_MASK =
		ADDR_MASK_WIDE[a64tw_pkg::ADDR_W-1:0];

	logic [a64tw_pkg::LEVEL_W-1:0] start_lvl;
	logic [a64tw_pkg::LEVEL_W-1:0] next_lvl;
	logic [a64tw_pkg::ADDR_W-1:0]  base_kept;
	logic [a64tw_pkg::ADDR_W-1:0]  desc_kept;
	logic [a64tw_pkg::ADDR_W-1:0]  bmask;
	logic [a64tw_pkg::ADDR_W-1:0]  first_addr;
	logic [a64tw_pkg::ADDR_W-1:0]  next_addr;
	logic [a64tw_pkg::ADDR_W-1:0]  final_addr;
	logic                          va_sz_bad;

	// address pieces; the index lands below bit 12 so no carry occurs
	always_comb begin
		start_lvl  = a64tw_pkg::walk_entry_level(cfg_va_sz);
		next_lvl   = cur.level + 2'd1;
		base_kept  = cfg_base & ADDR_MASK;
		desc_kept  = descriptor & ADDR_MASK;
		bmask      = a64tw_pkg::map_offset_mask(cur.level);
		first_addr = {base_kept[a64tw_pkg::ADDR_W-1:12],
			a64tw_pkg::va_index(virt_addr, start_lvl), 3'b000};
		next_addr  = {desc_kept[a64tw_pkg::ADDR_W-1:12],
			a64tw_pkg::va_index(cur.va, next_lvl), 3'b000};
		final_addr = (desc_kept & ~bmask) | (cur.va & bmask);
		va_sz_bad  = (cfg_va_sz < a64tw_pkg::VA_SZ_MIN) ||
			(cfg_va_sz > a64tw_pkg::VA_SZ_MAX);
	end

	// walk decision
	always_comb begin
		nxt       = cur;
		res.kind  = a64tw_pkg::KIND_BUSY;
		res.addr  = '0;
		res.level = a64tw_pkg::LEVEL_0;
		if (cmd == a64tw_pkg::CMD_TRANSLATE) begin
			// new request, refused while a walk is running
			if (!cur.walking) begin
				if (va_sz_bad) begin
					res.kind = a64tw_pkg::KIND_FAULT;
				end else begin
					nxt.walking = 1'b1;
					nxt.level   = start_lvl;
					nxt.va      = virt_addr;
					res.kind    = a64tw_pkg::KIND_READ;
					res.addr    = first_addr;
					res.level   = start_lvl;
				end
			end
		end else if (cur.walking) begin
			res.level = cur.level;
			if (bus_error || !descriptor[0]) begin
				// bus error or invalid descriptor
				nxt.walking = 1'b0;
				res.kind    = a64tw_pkg::KIND_FAULT;
			end else if (cur.level == a64tw_pkg::LEVEL_3) begin
				// page, or reserved encoding at the last level
				nxt.walking = 1'b0;
				if (descriptor[1]) begin
					res.kind = a64tw_pkg::KIND_DONE;
					res.addr = final_addr;
				end else begin
					res.kind = a64tw_pkg::KIND_FAULT;
				end
			end else if (descriptor[1]) begin
				// table descriptor: fetch from the next level
				nxt.level = next_lvl;
				res.kind  = a64tw_pkg::KIND_READ;
				res.addr  = next_addr;
				res.level = next_lvl;
			end else begin
				// block descriptor
				nxt.walking = 1'b0;
				res.kind    = a64tw_pkg::KIND_DONE;
				res.addr    = final_addr;
			end
		end
	end

endmodule
